### hw/rtl/assert_macros.svh
// Assertion macros shared by the timer table RTL.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising edge outside reset.
`define PTT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define PTT_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define PTT_ASSERT(lbl, clk, rst, prop, msg)
`define PTT_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

### hw/rtl/ptt_pkg.sv
package ptt_pkg;

   // Field widths of the item and result ports.
   localparam int KIND_W     = 2;
   localparam int TASK_W     = 8;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 3;
   localparam int ERR_W      = 8;

   // The subtract and compare unit works one bit wider than a period.
   localparam int ALU_W = DATA_W + 1;

   // At most this many fire results leave one tick.
   localparam int MAX_FIRES  = 8;
   localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CREATE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

   // Result kinds.
   localparam logic RESULT_STATUS = 1'b0;
   localparam logic RESULT_FIRE   = 1'b1;

   // Create and delete status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_PERIOD = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NULL_TASK   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL  = 2'd3;

   // One slot of the table as it is held in memory.
   typedef struct packed {
      logic [DATA_W-1:0] period;
      logic [DATA_W-1:0] counter;
      logic [TASK_W-1:0] task_id;
   } slot_entry_type;

   // Operands and outcome of the subtract and compare unit.
   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             ge;
   } alu_res_type;

endpackage

### hw/rtl/ptt_ram.sv
module ptt_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ptt_alu.sv
module ptt_alu
   import ptt_pkg::*;
(
   input  alu_req_type req,
   output alu_res_type res
);

   logic [ALU_W:0] wide;

   // Subtract with an extra bit so that the borrow gives the compare.
   always_comb begin
      wide     = {1'b0, req.a} - {1'b0, req.b};
      res.diff = wide[ALU_W-1:0];
      res.ge   = !wide[ALU_W];
   end

endmodule

### hw/rtl/periodic_task_timer_table_core.sv
// Channel   Handshake              Ports
// -------   --------------------   ---------------------------------------------
// item      start / busy           req_kind, req_task_id, req_period_ms
// result    rsp_valid (one cycle)  rsp_result_kind, rsp_status, rsp_fired_slot,
//                                  rsp_fired_task, rsp_error_count, rsp_last
//
// A create keeps busy high through ST_DIV and ST_CREATE: the reciprocal product
// for the division by TICK_MS is taken as the item is accepted, ST_DIV finishes
// the quotient and ST_CREATE checks and writes the slot.
// A delete of the null task or on an empty table is answered from idle; else each
// slot examined passes ST_DEL_RD and ST_DEL_CHK, since the slot read is registered.
// A tick passes each allocated slot through ST_TICK_RD and ST_TICK_UPD, then
// ST_TICK_END; fires leave at most one per slot. A tick on an empty table is free.
// Reset is synchronous and empties the table; results cannot be stalled.
`include "assert_macros.svh"

module periodic_task_timer_table_core
   import ptt_pkg::*;
#(
   parameter int SLOTS   = 8,
   parameter int TICK_MS = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [TASK_W-1:0]     req_task_id,
   input  logic [DATA_W-1:0]     req_period_ms,
   output logic                  rsp_valid,
   output logic                  rsp_result_kind,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_OUT_W-1:0] rsp_fired_slot,
   output logic [TASK_W-1:0]     rsp_fired_task,
   output logic [ERR_W-1:0]      rsp_error_count,
   output logic                  rsp_last
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int USED_W = $clog2(SLOTS + 1);

   // Exact division by TICK_MS: q = (x + hi(x * RECIP_LO)) >> RECIP_SHIFT, where the
   // full reciprocal is 2^DATA_W + RECIP_LO, rounded up.
   localparam int RECIP_SHIFT = $clog2(TICK_MS);
   localparam logic [2*DATA_W-1:0] RECIP_FULL =
      (((2*DATA_W)'(1) << (DATA_W + RECIP_SHIFT)) + (2*DATA_W)'(TICK_MS - 1)) /
      (2*DATA_W)'(TICK_MS);
   localparam logic [DATA_W-1:0] RECIP_LO = RECIP_FULL[DATA_W-1:0];

   // Sequencer states.
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DIV      = 3'd1;
   localparam logic [2:0] ST_CREATE   = 3'd2;
   localparam logic [2:0] ST_DEL_RD   = 3'd3;
   localparam logic [2:0] ST_DEL_CHK  = 3'd4;
   localparam logic [2:0] ST_TICK_RD  = 3'd5;
   localparam logic [2:0] ST_TICK_UPD = 3'd6;
   localparam logic [2:0] ST_TICK_END = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [TASK_W-1:0]     task_ff, task_in;
   logic [DATA_W-1:0]     quo_ff, quo_in;
   logic [DATA_W-1:0]     prod_hi_ff, prod_hi_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic [ERR_W-1:0]      rejects_ff, rejects_in;
   logic [FIRE_CNT_W-1:0] fires_ff, fires_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [TASK_W-1:0]     pend_task_ff, pend_task_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [TASK_W-1:0]     rsp_task_ff, rsp_task_in;
   logic [ERR_W-1:0]      rsp_err_ff, rsp_err_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  ram_wr_en;
   logic [SLOT_W-1:0]     ram_wr_addr;
   slot_entry_type        ram_wr_data;
   slot_entry_type        entry;
   alu_req_type           alu_req;
   alu_res_type           alu_res;
   logic [ALU_W-1:0]      count_inc;
   logic [2*DATA_W-1:0]   recip_prod;
   logic [DATA_W:0]       quo_sum;
   logic [DATA_W-1:0]     quo_calc;
   logic                  last_slot;
   logic [STATUS_W-1:0]   create_status;

   // Slot table memory.
   ptt_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (entry)
   );

   // Reciprocal product of the requested period; both operands are 32 bits wide.
   assign recip_prod = (2*DATA_W)'(req_period_ms) * (2*DATA_W)'(RECIP_LO);

   // The quotient follows from the held period and the high half of the product.
   assign quo_sum  = {1'b0, quo_ff} + {1'b0, prod_hi_ff};
   assign quo_calc = DATA_W'(quo_sum >> RECIP_SHIFT);

   // Subtractor: the period compare of a slot.
   assign count_inc = {1'b0, entry.counter} + ALU_W'(1);
   assign alu_req.a = count_inc;
   assign alu_req.b = {1'b0, entry.period};

   ptt_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   assign last_slot = (USED_W'(idx_ff) + USED_W'(1)) == used_ff;

   // Create checks in priority order on the quotient held after division.
   always_comb begin
      priority if (quo_ff == '0) begin
         create_status = STATUS_ZERO_PERIOD;
      end else if (task_ff == '0) begin
         create_status = STATUS_NULL_TASK;
      end else if (used_ff >= USED_W'(SLOTS)) begin
         create_status = STATUS_TABLE_FULL;
      end else begin
         create_status = STATUS_OK;
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      task_in       = task_ff;
      quo_in        = quo_ff;
      prod_hi_in    = prod_hi_ff;
      idx_in        = idx_ff;
      used_in       = used_ff;
      rejects_in    = rejects_ff;
      fires_in      = fires_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_task_in  = pend_task_ff;

      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_last_in   = rsp_last_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = entry;

      unique case (state_ff)
         ST_IDLE: begin
            fires_in      = '0;
            pend_valid_in = 1'b0;
            if (start) begin
               task_in = req_task_id;
               unique case (req_kind)
                  KIND_TICK: begin
                     idx_in = '0;
                     if (used_ff != '0) begin
                        state_in = ST_TICK_RD;
                     end
                  end
                  KIND_CREATE: begin
                     // The product is taken now; the quotient follows next cycle.
                     quo_in     = req_period_ms;
                     prod_hi_in = recip_prod[2*DATA_W-1:DATA_W];
                     state_in   = ST_DIV;
                  end
                  KIND_DELETE: begin
                     idx_in = '0;
                     if (req_task_id == '0 || used_ff == '0) begin
                        // Nothing can match: answer at once.
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = RESULT_STATUS;
                        rsp_status_in = STATUS_OK;
                        rsp_slot_in   = '0;
                        rsp_task_in   = '0;
                        rsp_err_in    = rejects_ff;
                        rsp_last_in   = 1'b1;
                     end else begin
                        state_in = ST_DEL_RD;
                     end
                  end
                  default: begin
                     // The unused kind is dropped.
                  end
               endcase
            end
         end

         ST_DIV: begin
            // Finish the division by the tick length.
            quo_in   = quo_calc;
            state_in = ST_CREATE;
         end

         ST_CREATE: begin
            if (create_status != STATUS_OK) begin
               rejects_in = rejects_ff + ERR_W'(1);
            end else begin
               ram_wr_en           = 1'b1;
               ram_wr_addr         = SLOT_W'(used_ff);
               ram_wr_data.period  = quo_ff;
               ram_wr_data.counter = '0;
               ram_wr_data.task_id = task_ff;
               used_in             = used_ff + USED_W'(1);
            end
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = RESULT_STATUS;
            rsp_status_in = create_status;
            rsp_slot_in   = '0;
            rsp_task_in   = '0;
            rsp_err_in    = (create_status != STATUS_OK) ? rejects_ff + ERR_W'(1)
                                                         : rejects_ff;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_DEL_RD: begin
            state_in = ST_DEL_CHK;
         end

         ST_DEL_CHK: begin
            if (entry.task_id == task_ff || last_slot) begin
               // First match is cleared; the slot keeps its period and count.
               if (entry.task_id == task_ff) begin
                  ram_wr_en           = 1'b1;
                  ram_wr_data.task_id = '0;
               end
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = RESULT_STATUS;
               rsp_status_in = STATUS_OK;
               rsp_slot_in   = '0;
               rsp_task_in   = '0;
               rsp_err_in    = rejects_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = ST_DEL_RD;
            end
         end

         ST_TICK_RD: begin
            state_in = ST_TICK_UPD;
         end

         ST_TICK_UPD: begin
            if (entry.period != '0) begin
               ram_wr_en           = 1'b1;
               ram_wr_data.counter = alu_res.ge ? '0 : count_inc[DATA_W-1:0];
               if (alu_res.ge && entry.task_id != '0 &&
                   fires_ff < FIRE_CNT_W'(MAX_FIRES)) begin
                  // Hold the newest fire back until it is known whether it ends the item.
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = RESULT_FIRE;
                     rsp_status_in = STATUS_OK;
                     rsp_slot_in   = SLOT_OUT_W'(pend_slot_ff);
                     rsp_task_in   = pend_task_ff;
                     rsp_err_in    = rejects_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = idx_ff;
                  pend_task_in  = entry.task_id;
                  fires_in      = fires_ff + FIRE_CNT_W'(1);
               end
            end
            if (last_slot) begin
               state_in = ST_TICK_END;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = ST_TICK_RD;
            end
         end

         ST_TICK_END: begin
            if (pend_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = RESULT_FIRE;
               rsp_status_in = STATUS_OK;
               rsp_slot_in   = SLOT_OUT_W'(pend_slot_ff);
               rsp_task_in   = pend_task_ff;
               rsp_err_in    = rejects_ff;
               rsp_last_in   = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         rejects_ff    <= '0;
         fires_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rejects_ff    <= rejects_in;
         fires_ff      <= fires_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      task_ff       <= task_in;
      quo_ff        <= quo_in;
      prod_hi_ff    <= prod_hi_in;
      idx_ff        <= idx_in;
      pend_slot_ff  <= pend_slot_in;
      pend_task_ff  <= pend_task_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_fired_slot  = rsp_slot_ff;
   assign rsp_fired_task  = rsp_task_ff;
   assign rsp_error_count = rsp_err_ff;
   assign rsp_last        = rsp_last_ff;

   // A status result is always the only result of its item.
   `PTT_ASSERT(a_status_is_last, clock, reset, rsp_valid && !rsp_result_kind |-> rsp_last, "status result without last")
   // The final result of an item is shown while the block is ready again.
   `PTT_ASSERT(a_last_frees_block, clock, reset, rsp_valid && rsp_last |-> !busy, "busy during final result")
   // Fire results come only from the tick walk.
   `PTT_ASSERT(a_fire_from_walk, clock, reset, rsp_valid && rsp_result_kind |-> $past(state_ff) == ST_TICK_UPD || $past(state_ff) == ST_TICK_END, "fire result outside a tick")
   // The fire cap and the allocation count stay in range.
   `PTT_ASSERT_NEVER(a_fire_cap, clock, reset, fires_ff > FIRE_CNT_W'(MAX_FIRES), "too many fires in one tick")
   `PTT_ASSERT_NEVER(a_used_bound, clock, reset, used_ff > USED_W'(SLOTS), "slot count beyond table size")

endmodule

### tb/sv/periodic_task_timer_table_core_test.sv
module periodic_task_timer_table_core_test;
   import ptt_pkg::*;

   localparam int TABLE_SLOTS   = 8;
   localparam int TICK_LEN_MS   = 1;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 100;
   localparam int PHASE_ITEMS   = 57;
   localparam int REPORT_LIMIT  = 10;

   // The package names no code for the unused kind.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // One item waiting to be offered, with the pacing it should get.
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [TASK_W-1:0] task_id;
      logic [DATA_W-1:0] period_ms;
      int                idle_pct;
      bit                wait_drain;
   } timer_command_type;

   // One result as it leaves the block.
   typedef struct packed {
      logic                  result_kind;
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [TASK_W-1:0]     task_id;
      logic [ERR_W-1:0]      errors;
      logic                  last;
   } timer_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [TASK_W-1:0]     req_task_id = '0;
   logic [DATA_W-1:0]     req_period_ms = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic                  rsp_result_kind;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_fired_slot;
   logic [TASK_W-1:0]     rsp_fired_task;
   logic [ERR_W-1:0]      rsp_error_count;
   logic                  rsp_last;

   // Shadow copy of the timer table.
   logic [DATA_W-1:0] slot_period [TABLE_SLOTS];
   logic [DATA_W-1:0] slot_count [TABLE_SLOTS];
   logic [TASK_W-1:0] slot_owner [TABLE_SLOTS];
   int                slots_taken = 0;
   logic [ERR_W-1:0]  reject_count = '0;

   timer_command_type command_queue [$];
   timer_outcome_type pending_outcomes [$];
   int                issued_items = 0;
   int                accepted_items = 0;
   int                mismatch_count = 0;
   int                cycle_count = 0;

   periodic_task_timer_table_core #(
      .SLOTS   (TABLE_SLOTS),
      .TICK_MS (TICK_LEN_MS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_task_id     (req_task_id),
      .req_period_ms   (req_period_ms),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_status      (rsp_status),
      .rsp_fired_slot  (rsp_fired_slot),
      .rsp_fired_task  (rsp_fired_task),
      .rsp_error_count (rsp_error_count),
      .rsp_last        (rsp_last)
   );

   always #6 clock = ~clock;

   // Builds one result carrying the error count as it stands now.
   function automatic timer_outcome_type make_outcome(logic rk, logic [STATUS_W-1:0] st,
                                                      int slot, logic [TASK_W-1:0] owner);
      timer_outcome_type o;
      o.result_kind = rk;
      o.status      = st;
      o.slot        = slot[SLOT_OUT_W-1:0];
      o.task_id     = owner;
      o.errors      = reject_count;
      o.last        = 1'b0;
      return o;
   endfunction

   // Applies one accepted item to the shadow table and queues its results.
   task automatic timer_table_step(input logic [KIND_W-1:0] kind,
                                   input logic [TASK_W-1:0] tid,
                                   input logic [DATA_W-1:0] ms);
      logic [DATA_W-1:0]   ticks;
      logic [STATUS_W-1:0] verdict;
      timer_outcome_type   batch [$];
      bit                  found;
      found = 1'b0;
      case (kind)
         KIND_CREATE: begin
            ticks = ms / TICK_LEN_MS;
            if (ticks == 0) verdict = STATUS_ZERO_PERIOD;
            else if (tid == 0) verdict = STATUS_NULL_TASK;
            else if (slots_taken >= TABLE_SLOTS) verdict = STATUS_TABLE_FULL;
            else verdict = STATUS_OK;
            if (verdict != STATUS_OK) begin
               reject_count = reject_count + 1'b1;
            end else begin
               slot_period[slots_taken] = ticks;
               slot_count[slots_taken]  = '0;
               slot_owner[slots_taken]  = tid;
               slots_taken++;
            end
            batch.push_back(make_outcome(RESULT_STATUS, verdict, 0, '0));
         end
         KIND_DELETE: begin
            // Only the first slot holding the task loses it.
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (!found && slot_owner[i] == tid) begin
                  slot_owner[i] = '0;
                  found = 1'b1;
               end
            end
            batch.push_back(make_outcome(RESULT_STATUS, STATUS_OK, 0, '0));
         end
         KIND_TICK: begin
            // Every allocated slot counts; a deleted slot clears silently.
            for (int i = 0; i < slots_taken; i++) begin
               if (slot_period[i] != 0) begin
                  slot_count[i] = slot_count[i] + 1'b1;
                  if (slot_count[i] >= slot_period[i]) begin
                     slot_count[i] = '0;
                     if (slot_owner[i] != 0 && batch.size() < MAX_FIRES)
                        batch.push_back(make_outcome(RESULT_FIRE, STATUS_OK, i,
                                                     slot_owner[i]));
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending_outcomes.push_back(batch[i]);
   endtask

   // Compares one result with the oldest one awaited.
   task automatic check_outcome(input timer_outcome_type got);
      timer_outcome_type want;
      if (pending_outcomes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: kind %0d status %0d slot %0d task %0h err %0d last %0d",
                     got.result_kind, got.status, got.slot, got.task_id, got.errors,
                     got.last);
      end else begin
         want = pending_outcomes.pop_front();
         if (got.result_kind !== want.result_kind || got.status !== want.status ||
             got.slot !== want.slot || got.task_id !== want.task_id ||
             got.errors !== want.errors || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("mismatch: expected kind %0d status %0d slot %0d task %0h err %0d last %0d",
                        want.result_kind, want.status, want.slot, want.task_id,
                        want.errors, want.last);
               $display("          got      kind %0d status %0d slot %0d task %0h err %0d last %0d",
                        got.result_kind, got.status, got.slot, got.task_id,
                        got.errors, got.last);
            end
         end
      end
   endtask

   task automatic queue_command(input logic [KIND_W-1:0] kind, input logic [TASK_W-1:0] tid,
                                input logic [DATA_W-1:0] ms, input int idle,
                                input bit drain);
      timer_command_type c;
      c.kind       = kind;
      c.task_id    = tid;
      c.period_ms  = ms;
      c.idle_pct   = idle;
      c.wait_drain = drain;
      command_queue.push_back(c);
   endtask

   // Driver: offers the next item at the falling edge and holds it until taken.
   always @(negedge clock) begin : drive_items
      timer_command_type next_cmd;
      if (!reset && !(start && accepted_items != issued_items)) begin
         if (command_queue.size() != 0 &&
             !(command_queue[0].wait_drain && pending_outcomes.size() != 0) &&
             $urandom_range(99) >= command_queue[0].idle_pct) begin
            next_cmd      = command_queue.pop_front();
            req_kind      <= next_cmd.kind;
            req_task_id   <= next_cmd.task_id;
            req_period_ms <= next_cmd.period_ms;
            start         <= 1'b1;
            issued_items++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks results, then records an item taken at this edge.
   always @(posedge clock) begin : watch_block
      timer_outcome_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("periodic_task_timer_table_core test failed");
         $finish;
      end else if (!reset) begin
         if (rsp_valid) begin
            got.result_kind = rsp_result_kind;
            got.status      = rsp_status;
            got.slot        = rsp_fired_slot;
            got.task_id     = rsp_fired_task;
            got.errors      = rsp_error_count;
            got.last        = rsp_last;
            check_outcome(got);
         end
         if (start && !busy) begin
            timer_table_step(req_kind, req_task_id, req_period_ms);
            accepted_items++;
         end
      end
   end

   initial begin : stimulus
      logic [TASK_W-1:0] known_ids [7] = '{8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h3C, 8'hC3};
      logic [KIND_W-1:0] kind;
      logic [TASK_W-1:0] tid;
      logic [DATA_W-1:0] ms;
      int                idle;
      int                pick;

      foreach (slot_period[i]) begin
         slot_period[i] = '0;
         slot_count[i]  = '0;
         slot_owner[i]  = '0;
      end

      // Directed part: rejects in their order of precedence, extremes, a
      // duplicate task, a silent slot after delete, a full table and kind 3.
      queue_command(KIND_TICK,   8'h00, 32'h0,        0, 1'b0);
      queue_command(KIND_CREATE, 8'h10, 32'h0,        0, 1'b0);
      queue_command(KIND_CREATE, 8'h00, 32'h0,        0, 1'b0);
      queue_command(KIND_CREATE, 8'h00, 32'hFFFFFFFF, 0, 1'b0);
      queue_command(KIND_CREATE, 8'hFF, 32'd1,        0, 1'b0);
      queue_command(KIND_CREATE, 8'h01, 32'hFFFFFFFF, 0, 1'b0);
      queue_command(KIND_CREATE, 8'h80, 32'd2,        0, 1'b0);
      queue_command(KIND_CREATE, 8'h55, 32'd3,        0, 1'b0);
      queue_command(KIND_CREATE, 8'h55, 32'd1,        0, 1'b0);
      queue_command(KIND_TICK,   8'h00, 32'h0,        0, 1'b0);
      queue_command(KIND_TICK,   8'hFF, 32'hFFFFFFFF, 0, 1'b0);
      queue_command(KIND_DELETE, 8'h55, 32'h0,        0, 1'b0);
      queue_command(KIND_TICK,   8'h00, 32'h0,        0, 1'b0);
      queue_command(KIND_CREATE, 8'hAA, 32'd4,        0, 1'b0);
      queue_command(KIND_CREATE, 8'h3C, 32'd1,        0, 1'b0);
      queue_command(KIND_CREATE, 8'hC3, 32'd1,        0, 1'b0);
      queue_command(KIND_CREATE, 8'h99, 32'd5,        0, 1'b0);
      queue_command(KIND_CREATE, 8'h00, 32'h0,        0, 1'b0);
      queue_command(KIND_CREATE, 8'h00, 32'd7,        0, 1'b0);
      queue_command(KIND_DELETE, 8'h00, 32'h0,        0, 1'b0);
      queue_command(KIND_DELETE, 8'h42, 32'h0,        0, 1'b0);
      queue_command(KIND_UNUSED, 8'hFF, 32'hFFFFFFFF, 0, 1'b0);
      queue_command(KIND_TICK,   8'h00, 32'h0,        0, 1'b0);
      queue_command(KIND_TICK,   8'h00, 32'h0,        0, 1'b0);

      // Random part in four pacing phases, each opened after a full drain.
      for (int n = 0; n < 4 * PHASE_ITEMS; n++) begin
         case (n / PHASE_ITEMS)
            1:       idle = 80;
            3:       idle = 16;
            default: idle = 0;
         endcase
         tid  = TASK_W'($urandom_range(255));
         ms   = $urandom;
         pick = $urandom_range(99);
         if (pick < 50) begin
            kind = KIND_TICK;
         end else if (pick < 75) begin
            kind = KIND_CREATE;
            pick = $urandom_range(99);
            if (pick < 10) ms = '0;
            else if (pick < 45) ms = $urandom_range(8, 1);
            if ($urandom_range(9) == 0) tid = '0;
         end else if (pick < 93) begin
            kind = KIND_DELETE;
            pick = $urandom_range(99);
            if (pick < 60) tid = known_ids[$urandom_range(6)];
            else if (pick < 70) tid = '0;
         end else begin
            kind = KIND_UNUSED;
         end
         queue_command(kind, tid, ms, idle,
                       (n % PHASE_ITEMS == 0) || ($urandom_range(99) < 3));
      end

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Wait for every item to be taken and every result to arrive.
      while (command_queue.size() != 0 || accepted_items != issued_items ||
             pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("periodic_task_timer_table_core test passed");
      end else begin
         $display("periodic_task_timer_table_core test failed");
      end
      $finish;
   end

endmodule
